>>> hdl/dr_pkg.sv
// shared types, constants and helper functions for the delta r pipeline
`default_nettype none
package dr_pkg;

  localparam int OUT_WIDTH   = 22;
  localparam int SQRT_STEPS  = 32;
  localparam int CORDIC_STEPS = 32;
  localparam int LOG_STEPS   = 28;

  // angles in q30, wide enough for 2pi and signed differences
  typedef logic signed [35:0] ang_t;
  // pseudorapidity in q20
  typedef logic signed [35:0] eta_t;

  localparam ang_t PI_Q30     = 36'sd3373259426;
  localparam ang_t TWO_PI_Q30 = 36'sd6746518852;
  localparam ang_t HALF_PI_Q30 = 36'sd1686629713;
  localparam ang_t THREE_HALF_PI_Q30 = 36'sd5059889139;

  localparam eta_t SENTINEL_Q20 = 36'sd1047527424;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  // 56 in q28, removes the q28 scaling of the doubled log2 of |p|+|pz|
  localparam logic signed [36:0] LOG_BIAS = 37'sd15032385536;

  // arctan(2^-i) in q30, rounded to nearest
  function automatic ang_t atan_q30(input int i);
    ang_t a;
    case (i)
      0: a = 36'sd843314857;
      1: a = 36'sd497837829;
      2: a = 36'sd263043837;
      3: a = 36'sd133525159;
      4: a = 36'sd67021687;
      5: a = 36'sd33543516;
      6: a = 36'sd16775851;
      7: a = 36'sd8388437;
      8: a = 36'sd4194283;
      9: a = 36'sd2097149;
      31: a = 36'sd1;
      default: a = 36'sd1 <<< (30 - i);
    endcase
    return a;
  endfunction

  // position of the highest set bit, zero for a zero word
  function automatic logic [4:0] msb32(input logic [31:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 5'(i);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

>>> hdl/dr_in_if.sv
// input channel: two momentum vectors per transfer
`default_nettype none
interface dr_in_if #(parameter int W = 18);
  logic valid;
  logic ready;
  logic signed [W-1:0] first_px;
  logic signed [W-1:0] first_py;
  logic signed [W-1:0] first_pz;
  logic signed [W-1:0] second_px;
  logic signed [W-1:0] second_py;
  logic signed [W-1:0] second_pz;

  modport source (output valid, first_px, first_py, first_pz,
                  second_px, second_py, second_pz, input ready);
  modport sink (input valid, first_px, first_py, first_pz,
                second_px, second_py, second_pz, output ready);
endinterface
`default_nettype wire

>>> hdl/dr_out_if.sv
// result channel: delta r and saturation flag per transfer
`default_nettype none
interface dr_out_if;
  logic valid;
  logic ready;
  logic [dr_pkg::OUT_WIDTH-1:0] delta_r;
  logic clipped;

  modport source (output valid, delta_r, clipped, input ready);
  modport sink (input valid, delta_r, clipped, output ready);
endinterface
`default_nettype wire

>>> hdl/delta_r_from_momenta.sv
// top level: delta r between two momentum vectors, fully pipelined
//
// in_ch carries one particle pair per transfer (px, py, pz of each, signed).
// out_ch returns delta r with FRAC_BITS fraction bits, saturated at 2^22-1,
// and a clipped flag set when saturation took place.
// one pair is taken every cycle while the output is not stalled; the pipeline
// has 109 register stages: the eta path (square root, two log2 units of 28
// squaring stages, ln2 scaling) with the cordic azimuth delayed to match,
// then the difference, magnitude, fold, square and sum registers, a 32-stage
// square root and the rounding output register.
// every stage advances together: when a finished result is held at the
// output and out_ch.ready is low, the whole pipeline freezes and in_ch.ready
// drops, so nothing is lost or repeated; an empty output slot keeps it moving.
// reset clears only the valid bits, the data path needs no reset.
`default_nettype none
module delta_r_from_momenta #(
  parameter int MOMENTUM_WIDTH = 18,
  parameter int FRAC_BITS      = 12
) (
  input wire logic clk,
  input wire logic rst_n,
  dr_in_if.sink    in_ch,
  dr_out_if.source out_ch
);

  // pipeline depth: eta path, pair stages, final root, output register
  localparam int LAT     = 109;
  localparam int PHI_DLY = 35;
  localparam int DROP    = 20 - FRAC_BITS;
  localparam logic [32:0] HALF = (33'd1 << DROP) >> 1;
  localparam logic [32:0] MAXV = (33'd1 << dr_pkg::OUT_WIDTH) - 33'd1;

  logic           en;
  logic [LAT-1:0] vld_r;

  dr_pkg::eta_t eta_a, eta_b;
  dr_pkg::ang_t phi_a, phi_b;
  dr_pkg::ang_t phia_d [0:PHI_DLY-1];
  dr_pkg::ang_t phib_d [0:PHI_DLY-1];

  logic signed [36:0] deta_r, d_r;
  logic [31:0] de2_r, de3_r;
  logic [33:0] ad_r;
  logic [33:0] fold;
  logic [34:0] fold_rnd;
  logic [23:0] dph_r;
  logic [63:0] sqe_r;
  logic [47:0] sqp_r;
  logic [63:0] sum_r;
  logic [31:0] root;
  logic [32:0] res;

  logic [dr_pkg::OUT_WIDTH-1:0] delta_r_r;
  logic                         clipped_r;

  // the pipeline moves unless a result is held at a stalled output
  assign en = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // per-particle eta and phi
  dr_eta #(.W(MOMENTUM_WIDTH)) u_eta_a (
    .clk (clk), .en (en),
    .px (in_ch.first_px), .py (in_ch.first_py), .pz (in_ch.first_pz),
    .eta (eta_a)
  );

  dr_eta #(.W(MOMENTUM_WIDTH)) u_eta_b (
    .clk (clk), .en (en),
    .px (in_ch.second_px), .py (in_ch.second_py), .pz (in_ch.second_pz),
    .eta (eta_b)
  );

  dr_phi #(.W(MOMENTUM_WIDTH)) u_phi_a (
    .clk (clk), .en (en),
    .px (in_ch.first_px), .py (in_ch.first_py),
    .phi (phi_a)
  );

  dr_phi #(.W(MOMENTUM_WIDTH)) u_phi_b (
    .clk (clk), .en (en),
    .px (in_ch.second_px), .py (in_ch.second_py),
    .phi (phi_b)
  );

  // azimuth is ready early, hold it until eta catches up
  always_ff @(posedge clk) begin
    if (en) begin
      phia_d[0] <= phi_a;
      phib_d[0] <= phi_b;
      for (int j = 1; j < PHI_DLY; j++) begin
        phia_d[j] <= phia_d[j-1];
        phib_d[j] <= phib_d[j-1];
      end
    end
  end

  // fold the azimuth difference into [0, pi], then round q30 to q20
  always_comb begin
    fold = (ad_r > 34'(dr_pkg::PI_Q30)) ? 34'(dr_pkg::TWO_PI_Q30) - ad_r : ad_r;
    fold_rnd = 35'(fold) + 35'd512;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // differences
      deta_r <= {eta_a[35], eta_a} - {eta_b[35], eta_b};
      d_r    <= {phia_d[PHI_DLY-1][35], phia_d[PHI_DLY-1]}
              - {phib_d[PHI_DLY-1][35], phib_d[PHI_DLY-1]};
      // magnitudes, |deta| stays below 2^31 even with both sentinels
      de2_r <= deta_r[36] ? 32'(-deta_r) : 32'(deta_r);
      ad_r  <= d_r[36] ? 34'(-d_r) : 34'(d_r);
      // fold and round
      de3_r <= de2_r;
      dph_r <= 24'(fold_rnd >> 10);
      // squares in q40
      sqe_r <= de3_r * de3_r;
      sqp_r <= dph_r * dph_r;
      // sum feeds the root
      sum_r <= sqe_r + 64'(sqp_r);
    end
  end

  dr_isqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sum_r),
    .root (root)
  );

  // round from q20 to the output fraction, saturate
  assign res = (33'(root) + HALF) >> DROP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (res > MAXV) begin
        delta_r_r <= MAXV[dr_pkg::OUT_WIDTH-1:0];
        clipped_r <= 1'b1;
      end else begin
        delta_r_r <= res[dr_pkg::OUT_WIDTH-1:0];
        clipped_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid   = vld_r[LAT-1];
  assign out_ch.delta_r = delta_r_r;
  assign out_ch.clipped = clipped_r;

  // a saturated result always carries the full-scale value
  a_clip_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.clipped |-> out_ch.delta_r == MAXV[dr_pkg::OUT_WIDTH-1:0])
    else $error("clipped result without full-scale value");

  // an input transfer enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted pair missing from first stage");

  // a stalled held result blocks new input
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output stalled");

  // a frozen pipeline keeps every valid bit
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> vld_r == $past(vld_r))
    else $error("valid bits moved during stall");

endmodule
`default_nettype wire

>>> hdl/dr_isqrt.sv
// pipelined 64-bit truncating integer square root, one result bit per stage
`default_nettype none
module dr_isqrt (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] rad,
  output      logic [31:0] root
);

  localparam int N = dr_pkg::SQRT_STEPS;

  logic [63:0] v_r   [0:N-1];
  logic [63:0] r_r   [0:N-1];
  logic [63:0] v_in  [0:N-1];
  logic [63:0] r_in  [0:N-1];
  logic [63:0] v_nxt [0:N-1];
  logic [63:0] r_nxt [0:N-1];

  for (genvar j = 0; j < N; j++) begin : g_in
    if (j == 0) begin : g_first
      assign v_in[j] = rad;
      assign r_in[j] = '0;
    end else begin : g_next
      assign v_in[j] = v_r[j-1];
      assign r_in[j] = r_r[j-1];
    end
  end

  always_comb begin
    logic [63:0] b;
    logic [63:0] trial;
    for (int j = 0; j < N; j++) begin
      b = 64'd1 << (62 - 2 * j);
      trial = r_in[j] + b;
      if (v_in[j] >= trial) begin
        v_nxt[j] = v_in[j] - trial;
        r_nxt[j] = (r_in[j] >> 1) + b;
      end else begin
        v_nxt[j] = v_in[j];
        r_nxt[j] = r_in[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < N; j++) begin
        v_r[j] <= v_nxt[j];
        r_r[j] <= r_nxt[j];
      end
    end
  end

  assign root = r_r[N-1][31:0];

endmodule
`default_nettype wire

>>> hdl/dr_log2.sv
// pipelined log2 in q28: normalize, then one squaring step per stage
`default_nettype none
module dr_log2 (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] val,
  output      logic [33:0] res
);

  localparam int N = dr_pkg::LOG_STEPS;

  // normalize stage a: leading one per half word
  logic [63:0] v_r;
  logic        hnz_r;
  logic [4:0]  mh_r;
  logic [4:0]  ml_r;
  // normalize stage b: exponent and mantissa with msb at bit 31
  logic [5:0]  e0_r;
  logic [31:0] m0_r;

  logic [5:0]  e_sel;
  logic [63:0] m_sh;

  logic [31:0]  m_r   [0:N-1];
  logic [N-1:0] f_r   [0:N-1];
  logic [5:0]   e_r   [0:N-1];
  logic [31:0]  m_in  [0:N-1];
  logic [N-1:0] f_in  [0:N-1];
  logic [5:0]   e_in  [0:N-1];
  logic [31:0]  m_nxt [0:N-1];
  logic [N-1:0] f_nxt [0:N-1];

  always_comb begin
    e_sel = hnz_r ? {1'b1, mh_r} : {1'b0, ml_r};
    if (e_sel >= 6'd31) m_sh = v_r >> (e_sel - 6'd31);
    else m_sh = v_r << (6'd31 - e_sel);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r   <= val;
      hnz_r <= |val[63:32];
      mh_r  <= dr_pkg::msb32(val[63:32]);
      ml_r  <= dr_pkg::msb32(val[31:0]);
      e0_r  <= e_sel;
      m0_r  <= m_sh[31:0];
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_in
    if (j == 0) begin : g_first
      assign m_in[j] = m0_r;
      assign f_in[j] = '0;
      assign e_in[j] = e0_r;
    end else begin : g_next
      assign m_in[j] = m_r[j-1];
      assign f_in[j] = f_r[j-1];
      assign e_in[j] = e_r[j-1];
    end
  end

  // squaring doubles the log; an overflow past 2.0 yields the next bit
  always_comb begin
    logic [63:0] sq;
    logic [32:0] t;
    for (int j = 0; j < N; j++) begin
      sq = m_in[j] * m_in[j];
      t = sq[63:31];
      if (t[32]) begin
        m_nxt[j] = t[32:1];
        f_nxt[j] = f_in[j] | (N'(1) << (N - 1 - j));
      end else begin
        m_nxt[j] = t[31:0];
        f_nxt[j] = f_in[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < N; j++) begin
        m_r[j] <= m_nxt[j];
        f_r[j] <= f_nxt[j];
        e_r[j] <= e_in[j];
      end
    end
  end

  assign res = {e_r[N-1], f_r[N-1]};

endmodule
`default_nettype wire

>>> hdl/dr_eta.sv
// pipelined pseudorapidity of one momentum vector, q20
`default_nettype none
module dr_eta #(
  parameter int W = 18
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [W-1:0] px,
  input  wire logic signed [W-1:0] py,
  input  wire logic signed [W-1:0] pz,
  output      dr_pkg::eta_t        eta
);

  typedef struct packed {
    logic neg;
    logic zz;
    logic ptz;
  } eta_flags_t;

  localparam int AZ_DLY  = 36;
  localparam int PT2_DLY = 34;
  localparam int K_DLY   = 32;
  localparam int FL_DLY  = 67;

  // magnitudes
  logic [W-1:0] ax_r, ay_r, az_r;
  logic         neg1_r, zz1_r;
  // squares
  logic [2*W-1:0] sqx_r, sqy_r, sqz_r;
  logic           neg2_r, zz2_r;
  // sums
  logic [63:0] pt2_r, s2_r;
  eta_flags_t  fl3_r;
  // leading one search of |p|^2
  logic [63:0] s2b_r;
  logic        hnz_r;
  logic [4:0]  mh_r, ml_r;
  // even normalization
  logic [63:0] sh_r;
  logic [4:0]  k_r;

  logic [5:0]  msb_s2;
  logic [4:0]  k_nxt;

  logic [W-1:0] az_d  [0:AZ_DLY-1];
  logic [63:0]  pt2_d [0:PT2_DLY-1];
  logic [4:0]   k_d   [0:K_DLY-1];
  eta_flags_t   fl_d  [0:FL_DLY-1];

  logic [31:0] root;
  logic [63:0] p28;
  logic [63:0] q28_r, pt2p_r;
  logic [33:0] lq, lp;

  logic signed [36:0] diff;
  logic [34:0] dcl_r;
  logic [46:0] ph_r;
  logic [47:0] pl_r;
  logic [63:0] prod;
  logic [24:0] emag;
  eta_flags_t  fl;
  dr_pkg::eta_t eta_nxt, eta_r;

  always_comb begin
    msb_s2 = hnz_r ? {1'b1, mh_r} : {1'b0, ml_r};
    k_nxt  = 5'((6'd63 - msb_s2) >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r   <= px[W-1] ? W'(-px) : W'(px);
      ay_r   <= py[W-1] ? W'(-py) : W'(py);
      az_r   <= pz[W-1] ? W'(-pz) : W'(pz);
      neg1_r <= pz[W-1];
      zz1_r  <= (pz == '0);

      sqx_r  <= ax_r * ax_r;
      sqy_r  <= ay_r * ay_r;
      sqz_r  <= az_r * az_r;
      neg2_r <= neg1_r;
      zz2_r  <= zz1_r;

      pt2_r     <= 64'(sqx_r) + 64'(sqy_r);
      s2_r      <= 64'(sqx_r) + 64'(sqy_r) + 64'(sqz_r);
      fl3_r.neg <= neg2_r;
      fl3_r.zz  <= zz2_r;
      fl3_r.ptz <= (sqx_r == '0) && (sqy_r == '0);

      s2b_r <= s2_r;
      hnz_r <= |s2_r[63:32];
      mh_r  <= dr_pkg::msb32(s2_r[63:32]);
      ml_r  <= dr_pkg::msb32(s2_r[31:0]);

      sh_r <= s2b_r << {k_nxt, 1'b0};
      k_r  <= k_nxt;
    end
  end

  // side data waiting for the square root
  always_ff @(posedge clk) begin
    if (en) begin
      az_d[0]  <= az_r;
      pt2_d[0] <= pt2_r;
      k_d[0]   <= k_r;
      fl_d[0]  <= fl3_r;
      for (int j = 1; j < AZ_DLY; j++) az_d[j] <= az_d[j-1];
      for (int j = 1; j < PT2_DLY; j++) pt2_d[j] <= pt2_d[j-1];
      for (int j = 1; j < K_DLY; j++) k_d[j] <= k_d[j-1];
      for (int j = 1; j < FL_DLY; j++) fl_d[j] <= fl_d[j-1];
    end
  end

  dr_isqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sh_r),
    .root (root)
  );

  // undo normalization into q28 and add |pz|
  always_comb begin
    if (k_d[K_DLY-1] >= 5'd28) p28 = 64'(root) >> (k_d[K_DLY-1] - 5'd28);
    else p28 = 64'(root) << (5'd28 - k_d[K_DLY-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q28_r  <= p28 + (64'(az_d[AZ_DLY-1]) << 28);
      pt2p_r <= pt2_d[PT2_DLY-1];
    end
  end

  dr_log2 u_log_q (
    .clk (clk),
    .en  (en),
    .val (q28_r),
    .res (lq)
  );

  dr_log2 u_log_p (
    .clk (clk),
    .en  (en),
    .val (pt2p_r),
    .res (lp)
  );

  // |eta| = ln2 * (log2(|p|+|pz|) - log2(pt^2) / 2), clamped at zero
  always_comb begin
    diff = $signed({2'b00, lq, 1'b0}) - dr_pkg::LOG_BIAS - $signed({3'b000, lp});
    prod = (64'(ph_r) << 18) + 64'(pl_r);
    emag = 25'((prod + (64'd1 << 38)) >> 39);
    fl   = fl_d[FL_DLY-1];
    if (fl.ptz) eta_nxt = fl.neg ? -dr_pkg::SENTINEL_Q20 : dr_pkg::SENTINEL_Q20;
    else if (fl.zz) eta_nxt = '0;
    else if (fl.neg) eta_nxt = -$signed(36'(emag));
    else eta_nxt = $signed(36'(emag));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dcl_r <= diff[36] ? '0 : diff[34:0];
      ph_r  <= dcl_r[34:18] * dr_pkg::LN2_Q30;
      pl_r  <= dcl_r[17:0] * dr_pkg::LN2_Q30;
      eta_r <= eta_nxt;
    end
  end

  assign eta = eta_r;

endmodule
`default_nettype wire

>>> hdl/dr_phi.sv
// pipelined azimuth of one momentum vector by cordic vectoring, q30 in [0, 2pi)
`default_nettype none
module dr_phi #(
  parameter int W = 18
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [W-1:0] px,
  input  wire logic signed [W-1:0] py,
  output      dr_pkg::ang_t        phi
);

  typedef struct packed {
    logic xz;
    logic pyp;
    logic base;
  } phi_flags_t;

  localparam int N = dr_pkg::CORDIC_STEPS;

  logic [W-1:0] ux1_r, uy1_r;
  logic         sx1_r, sy1_r, xz1_r, pyp1_r;
  logic [W-1:0] ux2_r, uy2_r;
  logic         sx2_r, sy2_r, xz2_r, pyp2_r;
  logic [4:0]   msb2_r;
  logic [W-1:0] mx;

  logic [5:0]         s_sh;
  logic [63:0]        xu, yu;
  logic signed [63:0] x0_r, y0_r;
  phi_flags_t         fl3_r;

  logic signed [63:0] x_r   [0:N-1];
  logic signed [63:0] y_r   [0:N-1];
  dr_pkg::ang_t       z_r   [0:N-1];
  logic signed [63:0] x_in  [0:N-1];
  logic signed [63:0] y_in  [0:N-1];
  dr_pkg::ang_t       z_in  [0:N-1];
  logic signed [63:0] x_nxt [0:N-1];
  logic signed [63:0] y_nxt [0:N-1];
  dr_pkg::ang_t       z_nxt [0:N-1];

  phi_flags_t   fl_d [0:N-1];
  dr_pkg::ang_t zb, phi_nxt, phi_r;

  assign mx = (ux1_r > uy1_r) ? ux1_r : uy1_r;

  // scale the larger magnitude to bit 58
  always_comb begin
    s_sh = 6'd58 - {1'b0, msb2_r};
    xu   = 64'(ux2_r) << s_sh;
    yu   = 64'(uy2_r) << s_sh;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux1_r  <= px[W-1] ? W'(-px) : W'(px);
      uy1_r  <= py[W-1] ? W'(-py) : W'(py);
      sx1_r  <= px[W-1];
      sy1_r  <= py[W-1];
      xz1_r  <= (px == '0);
      pyp1_r <= !py[W-1] && (py != '0);

      ux2_r  <= ux1_r;
      uy2_r  <= uy1_r;
      sx2_r  <= sx1_r;
      sy2_r  <= sy1_r;
      xz2_r  <= xz1_r;
      pyp2_r <= pyp1_r;
      msb2_r <= dr_pkg::msb32(32'(mx));

      // left half plane is mirrored and gets pi added at the end
      x0_r       <= $signed(xu);
      y0_r       <= (sx2_r ^ sy2_r) ? -$signed(yu) : $signed(yu);
      fl3_r.xz   <= xz2_r;
      fl3_r.pyp  <= pyp2_r;
      fl3_r.base <= sx2_r;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_in
    if (j == 0) begin : g_first
      assign x_in[j] = x0_r;
      assign y_in[j] = y0_r;
      assign z_in[j] = '0;
    end else begin : g_next
      assign x_in[j] = x_r[j-1];
      assign y_in[j] = y_r[j-1];
      assign z_in[j] = z_r[j-1];
    end
  end

  always_comb begin
    for (int j = 0; j < N; j++) begin
      if (y_in[j] > 0) begin
        x_nxt[j] = x_in[j] + (y_in[j] >>> j);
        y_nxt[j] = y_in[j] - (x_in[j] >>> j);
        z_nxt[j] = z_in[j] + dr_pkg::atan_q30(j);
      end else begin
        x_nxt[j] = x_in[j] - (y_in[j] >>> j);
        y_nxt[j] = y_in[j] + (x_in[j] >>> j);
        z_nxt[j] = z_in[j] - dr_pkg::atan_q30(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl_d[0] <= fl3_r;
      for (int j = 1; j < N; j++) fl_d[j] <= fl_d[j-1];
      for (int j = 0; j < N; j++) begin
        x_r[j] <= x_nxt[j];
        y_r[j] <= y_nxt[j];
        z_r[j] <= z_nxt[j];
      end
    end
  end

  // add back the quadrant, wrap into [0, 2pi), zero px overrides
  always_comb begin
    zb = z_r[N-1] + (fl_d[N-1].base ? dr_pkg::PI_Q30 : '0);
    if (zb < 0) zb = zb + dr_pkg::TWO_PI_Q30;
    if (fl_d[N-1].xz) begin
      phi_nxt = fl_d[N-1].pyp ? dr_pkg::HALF_PI_Q30 : dr_pkg::THREE_HALF_PI_Q30;
    end else begin
      phi_nxt = zb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) phi_r <= phi_nxt;
  end

  assign phi = phi_r;

endmodule
`default_nettype wire

>>> verif/testbench.sv
// testbench for delta_r_from_momenta: random and corner-case particle pairs, scoreboard check
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MW = 18;
  localparam int FB = 12;
  localparam int LATENCY = 109;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint unsigned LN2_Q30 = 64'd744261118;
  localparam longint SENTINEL_Q20 = 64'sd999 * 64'sd1048576;
  localparam logic [dr_pkg::OUT_WIDTH-1:0] DR_MAX = '1;

  typedef logic signed [MW-1:0] mom_t;
  typedef struct {
    mom_t ax, ay, az, bx, by, bz;
  } pair_t;
  typedef struct {
    logic [dr_pkg::OUT_WIDTH-1:0] delta_r;
    logic clipped;
  } dr_res_t;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;

  dr_in_if #(.W(MW)) in_ch();
  dr_out_if out_ch();

  delta_r_from_momenta #(.MOMENTUM_WIDTH(MW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  // delta r predictor and queue of pending results
  class dr_scoreboard;
    dr_res_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function int msb_pos(longint unsigned v);
      int n;
      n = 0;
      while ((v >> 1) != 0) begin
        v = v >> 1;
        n++;
      end
      return n;
    endfunction

    // truncated integer square root
    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // arctan(2^-i) in q30 from the series, rounded to nearest
    function longint atan_step(int i);
      longint sum, t;
      int e;
      sum = 0;
      if (i == 0) return (PI_Q30 + 2) >>> 2;
      for (int k = 0; k < 31; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e < 0) break;
        t = (64'sd1 <<< e) / longint'(2 * k + 1);
        sum = (k & 1) ? sum - t : sum + t;
      end
      return (sum + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // azimuth in q30, [0, 2pi), cordic vectoring
    function longint azimuth(longint px, longint py);
      longint unsigned ux, uy, m;
      longint x, y, z, base, xs, ys;
      int s;
      if (px == 0) return (py > 0) ? PI_Q30 / 2 : (3 * PI_Q30) / 2;
      ux = (px < 0) ? longint'(-px) : px;
      uy = (py < 0) ? longint'(-py) : py;
      m = (ux > uy) ? ux : uy;
      s = 0;
      z = 0;
      base = 0;
      while (m < (64'd1 << 58)) begin
        m = m << 1;
        s++;
      end
      x = longint'(ux << s);
      y = longint'(uy << s);
      if (py < 0) y = -y;
      if (px < 0) begin
        y = -y;
        base = PI_Q30;
      end
      for (int i = 0; i < dr_pkg::CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; z = z + atan_step(i);
        end else begin
          x = x - ys; y = y + xs; z = z - atan_step(i);
        end
      end
      z = z + base;
      if (z < 0) z = z + 2 * PI_Q30;
      return z;
    endfunction

    // log2 in q28 by repeated squaring
    function longint log2_q28(longint unsigned v);
      int e;
      longint unsigned m;
      longint res;
      e = msb_pos(v);
      m = (e >= 31) ? v >> (e - 31) : v << (31 - e);
      res = longint'(e) <<< 28;
      for (int k = 27; k >= 0; k--) begin
        m = (m * m) >> 31;
        if (m >= (64'd1 << 32)) begin
          m = m >> 1;
          res = res | (64'sd1 <<< k);
        end
      end
      return res;
    endfunction

    // pseudorapidity in q20
    function longint pseudorap(longint px, longint py, longint pz);
      longint unsigned ax, ay, az, pt2, s2, r, p28, q28, prod;
      longint diff, e;
      int k;
      ax = (px < 0) ? longint'(-px) : px;
      ay = (py < 0) ? longint'(-py) : py;
      az = (pz < 0) ? longint'(-pz) : pz;
      pt2 = ax * ax + ay * ay;
      if (pt2 == 0) return (pz < 0) ? -SENTINEL_Q20 : SENTINEL_Q20;
      if (pz == 0) return 0;
      s2 = pt2 + az * az;
      k = (63 - msb_pos(s2)) / 2;
      r = int_sqrt(s2 << (2 * k));
      p28 = (k >= 28) ? r >> (k - 28) : r << (28 - k);
      q28 = p28 + (az << 28);
      diff = 2 * log2_q28(q28) - (64'sd56 <<< 28) - log2_q28(pt2);
      if (diff < 0) diff = 0;
      prod = longint'(diff) * LN2_Q30;
      e = longint'((prod + (64'd1 << 38)) >> 39);
      return (pz < 0) ? -e : e;
    endfunction

    function dr_res_t predict_dr(pair_t p);
      longint deta, d;
      longint unsigned dphi20, de, sum, r, res;
      dr_res_t o;
      deta = pseudorap(p.ax, p.ay, p.az) - pseudorap(p.bx, p.by, p.bz);
      d = azimuth(p.ax, p.ay) - azimuth(p.bx, p.by);
      if (d < 0) d = -d;
      if (d > PI_Q30) d = 2 * PI_Q30 - d;
      dphi20 = (longint'(d) + 64'd512) >> 10;
      de = (deta < 0) ? longint'(-deta) : deta;
      sum = de * de + dphi20 * dphi20;
      r = int_sqrt(sum);
      res = (r + ((64'd1 << (20 - FB)) >> 1)) >> (20 - FB);
      if (res > longint'(DR_MAX)) begin
        o.delta_r = DR_MAX;
        o.clipped = 1'b1;
      end else begin
        o.delta_r = res[dr_pkg::OUT_WIDTH-1:0];
        o.clipped = 1'b0;
      end
      return o;
    endfunction

    function void note_pair(pair_t p);
      pending.insert(pending.size(), predict_dr(p));
    endfunction

    function void check_result(dr_res_t got);
      dr_res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result delta_r=%0d clipped=%0b", $realtime,
                 got.delta_r, got.clipped);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.delta_r !== want.delta_r) begin
        $display("%0t: delta_r mismatch expected %0d actual %0d", $realtime,
                 want.delta_r, got.delta_r);
        errors++;
      end
      if (got.clipped !== want.clipped) begin
        $display("%0t: clipped mismatch expected %0b actual %0b", $realtime,
                 want.clipped, got.clipped);
        errors++;
      end
    endfunction
  endclass

  dr_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // generous fixed bound on the whole run
  initial begin
    #400us;
    $display("== FAIL ==");
    $finish;
  end

  // sample both channels at the edge, before the driver's updates land
  always @(posedge clk) begin
    dr_res_t got;
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_pair('{in_ch.first_px, in_ch.first_py, in_ch.first_pz,
                     in_ch.second_px, in_ch.second_py, in_ch.second_pz});
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.delta_r = out_ch.delta_r;
      got.clipped = out_ch.clipped;
      sb.check_result(got);
    end
  end

  // receiver back-pressure, rate set per phase
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one transfer on the input channel, with random idle cycles ahead of it
  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.first_px  <= p.ax;
    in_ch.first_py  <= p.ay;
    in_ch.first_pz  <= p.az;
    in_ch.second_px <= p.bx;
    in_ch.second_py <= p.by;
    in_ch.second_pz <= p.bz;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // one momentum component: full range, small, zero or an extreme
  function automatic mom_t rand_comp();
    case ($urandom_range(9))
      0, 1, 2, 3: return mom_t'($urandom);
      4, 5: return mom_t'($signed($urandom_range(511)) - 256);
      6: return '0;
      7: return {1'b1, {(MW-1){1'b0}}};
      8: return {1'b0, {(MW-1){1'b1}}};
      default: return mom_t'($signed($urandom_range(4095)) - 2048);
    endcase
  endfunction

  // vector with a bias toward zero px, zero pt and zero pz
  task automatic rand_vec(output mom_t x, output mom_t y, output mom_t z);
    x = rand_comp();
    y = rand_comp();
    z = rand_comp();
    case ($urandom_range(15))
      0: x = '0;
      1: begin x = '0; y = '0; end
      2: z = '0;
      default: ;
    endcase
  endtask

  task automatic send_random(int count);
    pair_t p;
    repeat (count) begin
      rand_vec(p.ax, p.ay, p.az);
      rand_vec(p.bx, p.by, p.bz);
      send_pair(p);
    end
  endtask

  localparam mom_t MMAX = {1'b0, {(MW-1){1'b1}}};
  localparam mom_t MMIN = {1'b1, {(MW-1){1'b0}}};

  initial begin
    int waited;
    pair_t dir[$];
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.first_px = '0;
    in_ch.first_py = '0;
    in_ch.first_pz = '0;
    in_ch.second_px = '0;
    in_ch.second_py = '0;
    in_ch.second_pz = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    dir.insert(dir.size(), '{'0, '0, '0, '0, '0, '0});          // both zero vectors
    dir.insert(dir.size(), '{'0, '0, MMAX, '0, '0, MMIN});      // +999 against -999
    dir.insert(dir.size(), '{'0, '0, -18'sd5, '0, '0, 18'sd5}); // zero pt, pz of each sign
    dir.insert(dir.size(), '{'0, 18'sd7, 18'sd3, '0, -18'sd7, 18'sd3}); // zero px
    dir.insert(dir.size(), '{'0, '0, 18'sd9, 18'sd4, 18'sd4, '0});      // zero pt, pz>0
    dir.insert(dir.size(), '{18'sd100, '0, '0, -18'sd100, '0, '0});     // phi 0 against pi
    dir.insert(dir.size(), '{MMAX, MMAX, MMAX, MMIN, MMIN, MMIN});
    dir.insert(dir.size(), '{MMIN, MMAX, MMIN, MMAX, MMIN, MMAX});
    dir.insert(dir.size(), '{18'sd1, 18'sd1, 18'sd1, -18'sd1, -18'sd1, -18'sd1});
    dir.insert(dir.size(), '{18'sd1, '0, MMAX, 18'sd1, '0, MMIN}); // huge eta spread
    dir.insert(dir.size(), '{MMAX, 18'sd1, '0, MMAX, -18'sd1, '0}); // tiny dphi
    dir.insert(dir.size(), '{-18'sd1, '0, 18'sd1, 18'sd1, '0, -18'sd1});
    dir.insert(dir.size(), '{18'sd3, -18'sd4, 18'sd12, -18'sd3, 18'sd4, -18'sd12});
    dir.insert(dir.size(), '{'0, MMIN, '0, MMIN, '0, '0});
    foreach (dir[i]) send_pair(dir[i]);

    // phases: no idling, sender idle, receiver stall, both
    send_random(320);
    send_idle_pct = 46;
    send_random(320);
    send_idle_pct = 0;
    recv_stall_pct = 46;
    send_random(320);
    send_idle_pct = 24;
    recv_stall_pct = 24;
    send_random(320);
    in_ch.valid <= 1'b0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 20) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
